/* sv/stbs_pkg.sv */
// Shared constants and control types for the sorted table binary search block.
package stbs_pkg;

	localparam int unsigned DEPTH_DEF      = 128;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned INDEX_W  = 7;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned IDX_SPAN = 2 ** INDEX_W;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic write_entry;
		logic start_search;
		logic issue_probe;
		logic step;
		logic publish;
	} stbs_cmd_t;

	typedef struct packed {
		logic open;
		logic hit;
	} stbs_status_t;

endpackage

/* sv/stbs_req_if.sv */
// Request channel: command, load index and value with valid/ready handshake.
interface stbs_req_if import stbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [INDEX_W-1:0]        load_index;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output command, output load_index, output value,
		input ready);
	modport sink (input valid, input command, input load_index, input value,
		output ready);
endinterface

/* sv/stbs_rsp_if.sv */
// Response channel: found flag and position with valid/ready handshake.
interface stbs_rsp_if import stbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

/* sv/sorted_table_binary_search_core.sv */
// Sorted table binary search: holds an ascending table of signed words and
// answers key lookups.
// Channel req carries requests: command selects a load (write value at
// load_index, wrapped to the table depth) or a search for value. A load
// gives no response; a search gives one response on rsp: found and the
// matching position, or found low with position zero.
// cfg_we/cfg_wdata write entry_count, the number of entries searched from
// index zero (above the depth it is clamped to the depth). Write it only
// while no search is in flight.
// Sequence: a load is written into the table when accepted. A search repeats a
// probe (memory read at the midpoint, then compare and bound update) until a
// probe hits or the range is empty, with at most ceil(log2(count+1)) probes.
// One request is worked on at a time; the next can be accepted in the cycle the
// response is first presented.
// A finished response sits in an output register; the next request is taken
// while it waits. If the receiver stalls, a following search finishes its
// probes and then holds until the output register frees up.
// Reset clears entry_count, the sequencer and rsp.valid; table contents are
// undefined until loaded.
module sorted_table_binary_search_core import stbs_pkg::*; #(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	stbs_req_if.sink           req,
	stbs_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	stbs_cmd_t    cmd;
	stbs_status_t status;

	stbs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.cmd         (cmd),
		.status      (status)
	);

	stbs_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.load_index (req.load_index),
		.value      (req.value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.found      (rsp.found),
		.position   (rsp.position)
	);

endmodule

/* sv/stbs_ctrl.sv */
// Sequencer for loads, probe/compare steps and response handoff.
module stbs_ctrl import stbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic         req_command,
	output logic         req_ready,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output stbs_cmd_t    cmd,
	input  stbs_status_t status
);

	typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_CMP, ST_DONE} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid & req_ready;
	assign slot_free = ~rsp_valid_q | rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.write_entry  = accept & (req_command == CMD_LOAD);
		cmd.start_search = accept & (req_command == CMD_SEARCH);
		cmd.issue_probe  = (state_q == ST_CHECK) & status.open;
		cmd.step         = (state_q == ST_CMP);
		cmd.publish      = (state_q == ST_DONE) & slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start_search) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= status.open ? ST_CMP : ST_DONE;
				end
				ST_CMP: begin
					state_q <= status.hit ? ST_DONE : ST_CHECK;
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// hold the response until the receiver takes it
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/stbs_datapath.sv */
// Table memory, search bounds, probe compare and response register.
module stbs_datapath import stbs_pkg::*; #(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  stbs_cmd_t                 cmd,
	output stbs_status_t              status,
	input  logic [INDEX_W-1:0]        load_index,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      cfg_we,
	input  logic [COUNT_W-1:0]        cfg_wdata,
	output logic                      found,
	output logic [POS_W-1:0]          position
);

	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CW > COUNT_W) ? CW : COUNT_W;

	logic [DATA_WIDTH-1:0] table_mem [DEPTH];
	logic [AW-1:0]         wrap_idx [IDX_SPAN];

	logic [COUNT_W-1:0]    entry_count_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hi_q;
	logic [AW-1:0]         mid_q;
	logic                  found_q;
	logic [AW-1:0]         fpos_q;
	logic                  out_found_q;
	logic [POS_W-1:0]      out_pos_q;

	logic [DATA_WIDTH-1:0] word;
	logic [CMP_W-1:0]      count_ext;
	logic [CW-1:0]         count;
	logic [CW-1:0]         span;
	logic [CW-1:0]         mid_full;
	logic [AW-1:0]         mid;
	logic                  key_less;

	// load index wraps modulo the table depth
	for (genvar i = 0; i < IDX_SPAN; i++) begin : g_wrap
		localparam int unsigned WI = i % DEPTH;
		assign wrap_idx[i] = AW'(WI);
	end

	assign word      = DATA_WIDTH'(value);
	assign count_ext = (CMP_W'(entry_count_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
		: CMP_W'(entry_count_q);
	assign count     = CW'(count_ext);

	// midpoint of the inclusive range [lo, hi-1]
	assign span     = hi_q - lo_q - CW'(1);
	assign mid_full = lo_q + (span >> 1);
	assign mid      = mid_full[AW-1:0];
	assign key_less = $signed(key_q) < $signed(rd_q);

	assign status.open = lo_q < hi_q;
	assign status.hit  = (rd_q == key_q);
	assign found       = out_found_q;
	assign position    = out_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			table_mem[wrap_idx[load_index]] <= word;
		end
		if (cmd.issue_probe) begin
			rd_q <= table_mem[mid];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_search) begin
			key_q   <= word;
			lo_q    <= '0;
			hi_q    <= count;
			found_q <= 1'b0;
			fpos_q  <= '0;
		end
		if (cmd.issue_probe) begin
			mid_q <= mid;
		end
		if (cmd.step) begin
			if (status.hit) begin
				found_q <= 1'b1;
				fpos_q  <= mid_q;
			end else if (key_less) begin
				hi_q <= CW'(mid_q);
			end else begin
				lo_q <= CW'(mid_q) + CW'(1);
			end
		end
		if (cmd.publish) begin
			out_found_q <= found_q;
			out_pos_q   <= POS_W'(fpos_q);
		end
	end

endmodule

/* verif/sorted_table_binary_search_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_binary_search_core: loads, lookups, entry count.
module sorted_table_binary_search_core_tb;
	import stbs_pkg::*;

	typedef struct packed {
		logic                      command;
		logic [INDEX_W-1:0]        load_index;
		logic signed [VALUE_W-1:0] value;
	} table_request_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} lookup_result_t;

	localparam int unsigned SETTLE_CYCLES = 24;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	stbs_req_if req_ch ();
	stbs_rsp_if rsp_ch ();

	sorted_table_binary_search_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the block: table contents and entry count.
	logic signed [VALUE_W-1:0] entry_store [IDX_SPAN];
	logic [COUNT_W-1:0]        shadow_count;

	table_request_t pending_requests [$];
	lookup_result_t expected_lookups [$];

	int  accepted_requests;
	int  issued_items;
	int  mismatch_count;
	logic calm;

	// No idling on either side for a stretch in the middle of the run.
	assign calm = (accepted_requests >= 250) && (accepted_requests < 350);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic lookup_result_t lookup_key(input logic signed [VALUE_W-1:0] key);
		lookup_result_t r;
		int lo, hi, mid, span;
		logic done;
		r.found = 1'b0;
		r.position = '0;
		span = (shadow_count > DEPTH_DEF) ? DEPTH_DEF : shadow_count;
		lo = 0;
		hi = span - 1;
		done = 1'b0;
		while (!done && lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (entry_store[mid] == key) begin
				r.found = 1'b1;
				r.position = mid[POS_W-1:0];
				done = 1'b1;
			end else if (key < entry_store[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return r;
	endfunction

	// Request driver: predict on acceptance, then present the next pending request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= CMD_LOAD;
			req_ch.load_index <= '0;
			req_ch.value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				accepted_requests++;
				if (req_ch.command == CMD_LOAD)
					entry_store[req_ch.load_index] = req_ch.value;
				else
					expected_lookups.push_back(lookup_key(req_ch.value));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
					req_ch.valid <= 1'b1;
					req_ch.command <= pending_requests[0].command;
					req_ch.load_index <= pending_requests[0].load_index;
					req_ch.value <= pending_requests[0].value;
					void'(pending_requests.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare against the oldest expected lookup, stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_lookups.size() == 0) begin
					flag_mismatch($sformatf("unexpected response found=%0b position=%0d",
						rsp_ch.found, rsp_ch.position));
				end else begin
					if (rsp_ch.found !== expected_lookups[0].found)
						flag_mismatch($sformatf("found %0b, expected %0b",
							rsp_ch.found, expected_lookups[0].found));
					if (rsp_ch.position !== expected_lookups[0].position)
						flag_mismatch($sformatf("position %0d, expected %0d",
							rsp_ch.position, expected_lookups[0].position));
					void'(expected_lookups.pop_front());
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic queue_load(input int idx, input logic signed [VALUE_W-1:0] v);
		table_request_t r;
		r.command = CMD_LOAD;
		r.load_index = idx[INDEX_W-1:0];
		r.value = v;
		pending_requests.push_back(r);
		issued_items++;
	endtask

	task automatic queue_search(input logic signed [VALUE_W-1:0] key);
		table_request_t r;
		r.command = CMD_SEARCH;
		r.load_index = INDEX_W'($urandom_range(0, IDX_SPAN - 1));
		r.value = key;
		pending_requests.push_back(r);
		issued_items++;
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || req_ch.valid || expected_lookups.size() != 0)
			@(negedge clk);
	endtask

	// Write the count only with nothing in flight; let a trailing load settle first.
	task automatic set_entry_count(input logic [COUNT_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_count = v;
	endtask

	function automatic logic signed [VALUE_W-1:0] random_word(input int mode);
		case (mode)
			1: return $signed($urandom_range(0, 15)) - 8;
			2: return $signed($urandom_range(0, 2000)) - 1000;
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					default: return $urandom();
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic run_phase(input int phase_no);
		logic signed [VALUE_W-1:0] vals [IDX_SPAN];
		int order [IDX_SPAN];
		logic signed [VALUE_W-1:0] hold, key;
		int count, used, mode, j, k, tmp, searches;
		if (phase_no == 0)
			count = 0;
		else if (phase_no == 2)
			count = DEPTH_DEF;
		else if (phase_no == 6)
			count = 255;
		else if ($urandom_range(0, 9) == 0)
			count = 0;
		else if ($urandom_range(0, 7) == 0)
			count = $urandom_range(21, 64);
		else
			count = $urandom_range(1, 20);
		used = (count > DEPTH_DEF) ? DEPTH_DEF : count;
		set_entry_count(count[COUNT_W-1:0]);

		mode = $urandom_range(0, 3);
		for (j = 0; j < used; j++)
			vals[j] = random_word(mode);
		// Sort ascending so the table stays well formed.
		for (j = 1; j < used; j++) begin
			hold = vals[j];
			k = j - 1;
			while (k >= 0 && vals[k] > hold) begin
				vals[k + 1] = vals[k];
				k--;
			end
			vals[k + 1] = hold;
		end
		for (j = 0; j < used; j++)
			order[j] = j;
		for (j = used - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = order[j];
			order[j] = order[k];
			order[k] = tmp;
		end
		for (j = 0; j < used; j++)
			queue_load(order[j], vals[order[j]]);
		// Break the ordering now and then.
		if (used > 1 && phase_no % 6 == 5) begin
			k = $urandom_range(0, used - 1);
			vals[k] = $urandom();
			queue_load(k, vals[k]);
		end
		// Loads outside the searched range must not disturb the answer.
		if (used < DEPTH_DEF && $urandom_range(0, 4) == 0) begin
			for (j = 0; j < 3; j++)
				queue_load($urandom_range(used, DEPTH_DEF - 1), $urandom());
		end

		searches = $urandom_range(4, 16);
		for (j = 0; j < searches; j++) begin
			k = (used == 0) ? 0 : $urandom_range(0, used - 1);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: key = (used == 0) ? $urandom() : vals[k];
				6: key = (used == 0) ? 0 : vals[k] + ($urandom_range(0, 1) ? 1 : -1);
				7: key = $urandom();
				8: key = 32'sh8000_0000;
				default: key = 32'sh7FFF_FFFF;
			endcase
			queue_search(key);
		end
	endtask

	initial begin
		int phase_no;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.load_index = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		shadow_count = '0;
		accepted_requests = 0;
		issued_items = 0;
		mismatch_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table right after reset.
		queue_search(0);
		queue_search(32'sh8000_0000);
		// Sorted table with extremes and a run of duplicates.
		queue_load(7, 32'sh7FFF_FFFF);
		queue_load(6, 9);
		queue_load(5, 0);
		queue_load(4, 0);
		queue_load(3, 0);
		queue_load(2, -1);
		queue_load(1, -7);
		queue_load(0, 32'sh8000_0000);
		set_entry_count(COUNT_W'(8));
		queue_search(32'sh8000_0000);
		queue_search(32'sh7FFF_FFFF);
		queue_search(0);
		queue_search(-1);
		queue_search(9);
		queue_search(1);
		queue_search(-8);
		queue_search(32'sh7FFF_FFFE);
		set_entry_count(COUNT_W'(1));
		queue_search(32'sh8000_0000);
		queue_search(5);

		issued_items = 0;
		phase_no = 0;
		while (issued_items < 700) begin
			run_phase(phase_no);
			phase_no++;
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("** sorted_table_binary_search_core: PASSED **");
		else
			$display("** sorted_table_binary_search_core: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TIMEOUT: %0d lookups still outstanding", expected_lookups.size());
		$display("** sorted_table_binary_search_core: FAILED **");
		$finish;
	end

endmodule

/* sorted_table_binary_search_core.f */
sv/stbs_pkg.sv
sv/stbs_req_if.sv
sv/stbs_rsp_if.sv
sv/stbs_ctrl.sv
sv/stbs_datapath.sv
sv/sorted_table_binary_search_core.sv
verif/sorted_table_binary_search_core_tb.sv
